@@ hdl/kpset_pkg.sv @@
`default_nettype none

package kpset_pkg;

  // Set size and pair validity limits.
  localparam int CAPACITY  = 16;
  localparam int MAX_PLANS = 8;

  // Field widths fixed by the stream format.
  localparam int FUNC_W  = 2;
  localparam int PLAN_W  = 8;
  localparam int DATE_W  = 27;
  localparam int COUNT_W = 5;

  // Lowest valid date, decimal yyyymmdd.
  localparam logic [DATE_W-1:0] DATE_FLOOR = DATE_W'(20000101);

  // Widths of stored entries and of the set bookkeeping.
  localparam int SPLAN_W = (MAX_PLANS > 1) ? $clog2(MAX_PLANS) : 1;
  localparam int ENTRY_W = SPLAN_W + DATE_W;
  localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);

  // Operation codes carried in the func field.
  typedef enum logic [FUNC_W-1:0] {
    OP_QUERY  = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } func_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MISS,
    S_SHIFT,
    S_APPEND,
    S_RESULT
  } state_t;

endpackage

`default_nettype wire

@@ hdl/kpset_ram.sv @@
`default_nettype none

module kpset_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/keyed_pair_set_fifo_evict_core.sv @@
`default_nettype none

// Channel   Direction  Width  Contents
// s_axis    in         40     func, plan_index, date
// m_axis    out        8      status, found, evicted, entry_count
//
// One operation at a time. The set lives in a RAM with a registered read, scanned
// one entry per cycle; a removal or an eviction then moves the later entries
// down at one entry per cycle through the same read and write ports.
// A clear or an invalid pair goes straight to the result state; a miss scans every
// stored pair, and an insert then appends, first evicting the oldest if the set is full.
// Reset empties the set; the RAM itself is not cleared. A stalled result holds
// the next operation only at its end, in the result state.
module keyed_pair_set_fifo_evict_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [39:0] s_tdata,  // func[1:0], plan_index[9:2], date[36:10], zero pad
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic      [7:0] m_tdata    // status[0], found[1], evicted[2], entry_count[7:3]
);

  import kpset_pkg::*;

  localparam logic [CNT_W-1:0]  CAP_CNT  = CNT_W'(CAPACITY);
  localparam logic [ADDR_W-1:0] CAP_LAST = ADDR_W'(CAPACITY - 1);

  state_t state, state_next;

  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] chk, chk_next;
  logic             rd_pend, rd_pend_next;

  func_t            op;
  logic [PLAN_W-1:0] plan;
  logic [DATE_W-1:0] date;

  logic res_status, res_status_next;
  logic res_found, res_found_next;
  logic res_evicted, res_evicted_next;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // Fields of the incoming transaction.
  func_t             in_func;
  logic [PLAN_W-1:0] in_plan;
  logic [DATE_W-1:0] in_date;
  logic              in_key_ok;
  logic              accept;
  logic              out_load;
  logic              match;
  logic [CNT_W-1:0]  count_last;

  assign in_func   = func_t'(s_tdata[1:0]);
  assign in_plan   = s_tdata[9:2];
  assign in_date   = s_tdata[36:10];
  assign in_key_ok = (32'(in_plan) < MAX_PLANS) && (in_date >= DATE_FLOOR);
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign count_last = CNT_W'(count - 1'b1);

  // Only valid pairs are scanned, so the dropped plan bits are zero.
  assign match = (ram_rdata == {plan[SPLAN_W-1:0], date});

  kpset_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_entries (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      rd_pend <= rd_pend_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Operation fields, scan pointers and result payload.
  always_ff @(posedge clk) begin
    idx         <= idx_next;
    chk         <= chk_next;
    res_status  <= res_status_next;
    res_found   <= res_found_next;
    res_evicted <= res_evicted_next;
    if (accept) begin
      op   <= in_func;
      plan <= in_plan;
      date <= in_date;
    end
    if (out_load) begin
      m_tdata <= {5'(count), res_evicted, res_found, res_status};
    end
  end

  // Sequencer: scan, shift down and append.
  always_comb begin
    state_next       = state;
    count_next       = count;
    idx_next         = idx;
    chk_next         = chk;
    rd_pend_next     = 1'b0;
    res_status_next  = res_status;
    res_found_next   = res_found;
    res_evicted_next = res_evicted;
    ram_we           = 1'b0;
    ram_waddr        = chk[ADDR_W-1:0];
    ram_wdata        = {plan[SPLAN_W-1:0], date};
    ram_re           = 1'b0;
    ram_raddr        = idx[ADDR_W-1:0];
    out_load         = 1'b0;

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          res_status_next  = 1'b0;
          res_found_next   = 1'b0;
          res_evicted_next = 1'b0;
          idx_next         = '0;
          if (in_func == OP_CLEAR) begin
            count_next = '0;
            state_next = S_RESULT;
          end else if (!in_key_ok) begin
            res_status_next = (in_func == OP_INSERT);
            state_next      = S_RESULT;
          end else if (count == '0) begin
            state_next = S_MISS;
          end else begin
            state_next = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue the next read while checking the previous one.
        if (idx < count) begin
          ram_re       = 1'b1;
          idx_next     = CNT_W'(idx + 1'b1);
          chk_next     = idx;
          rd_pend_next = 1'b1;
        end
        if (rd_pend) begin
          if (match) begin
            res_found_next = 1'b1;
            rd_pend_next   = 1'b0;
            if (op == OP_REMOVE) begin
              if (chk == count_last) begin
                count_next = count_last;
                state_next = S_RESULT;
              end else begin
                idx_next   = CNT_W'(chk + 1'b1);
                state_next = S_SHIFT;
              end
            end else begin
              state_next = S_RESULT;
            end
          end else if (chk == count_last) begin
            rd_pend_next = 1'b0;
            state_next   = S_MISS;
          end
        end
      end

      S_MISS: begin
        if (op == OP_INSERT) begin
          if (count == CAP_CNT) begin
            res_evicted_next = 1'b1;
            if (CAPACITY > 1) begin
              idx_next   = CNT_W'(1);
              state_next = S_SHIFT;
            end else begin
              state_next = S_APPEND;
            end
          end else begin
            state_next = S_APPEND;
          end
        end else begin
          state_next = S_RESULT;
        end
      end

      S_SHIFT: begin
        // Read entry idx, write the entry read last cycle one place lower.
        if (idx < count) begin
          ram_re       = 1'b1;
          idx_next     = CNT_W'(idx + 1'b1);
          chk_next     = idx;
          rd_pend_next = 1'b1;
        end
        if (rd_pend) begin
          ram_we    = 1'b1;
          ram_waddr = ADDR_W'(chk - 1'b1);
          ram_wdata = ram_rdata;
          if (chk == count_last) begin
            rd_pend_next = 1'b0;
            if (op == OP_REMOVE) begin
              count_next = count_last;
              state_next = S_RESULT;
            end else begin
              state_next = S_APPEND;
            end
          end
        end
      end

      S_APPEND: begin
        ram_we = 1'b1;
        if (count == CAP_CNT) begin
          ram_waddr = CAP_LAST;
        end else begin
          ram_waddr  = count[ADDR_W-1:0];
          count_next = CNT_W'(count + 1'b1);
        end
        state_next = S_RESULT;
      end

      S_RESULT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // The set never grows past its capacity.
  assert property (@(posedge clk) disable iff (rst) count <= CAP_CNT)
    else $error("stored count above capacity");

  // A rejected insert neither finds nor evicts.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && (m_tdata[1] || m_tdata[2])))
    else $error("rejected insert reports found or evicted");

  // An eviction leaves the set full.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2]) |-> (m_tdata[7:3] == 5'(CAPACITY)))
    else $error("eviction without a full set");

  // The RAM is written only while an operation is in progress.
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_SHIFT || state == S_APPEND))
    else $error("entry write outside shift or append");

  // An accepted transaction always leaves the idle state.
  assert property (@(posedge clk) disable iff (rst) accept |=> (state != S_IDLE))
    else $error("accepted transaction not started");

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`default_nettype none

module tb;
  import kpset_pkg::*;

  // One result as the block reports it.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               evicted;
    logic               found;
    logic               status;
  } set_outcome_t;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 20;
  localparam logic [DATE_W-1:0] DATE_TOP = DATE_W'(99999999);

  logic                clk;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [39:0]         s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [7:0]          m_tdata;

  // Shadow copy of the stored set, kept in insertion order.
  logic [PLAN_W-1:0]   set_plan [CAPACITY];
  logic [DATE_W-1:0]   set_date [CAPACITY];
  int                  set_count = 0;

  set_outcome_t        outcome_q [$];
  int                  error_count = 0;
  logic                idle_on = 1'b1;
  int                  stall_token = 0;
  int                  stall_seen = 0;
  int                  hold_left = 0;

  keyed_pair_set_fifo_evict_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #10000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Removes one stored pair and closes the gap behind it.
  function automatic void drop_entry(input int pos);
    for (int i = pos + 1; i < set_count; i++) begin
      set_plan[i-1] = set_plan[i];
      set_date[i-1] = set_date[i];
    end
    set_count--;
  endfunction

  // Applies one operation to the shadow set and returns the result it must produce.
  function automatic set_outcome_t apply_operation(input func_t op,
                                                   input logic [PLAN_W-1:0] plan,
                                                   input logic [DATE_W-1:0] date);
    set_outcome_t r;
    bit           pair_valid;
    int           pos;
    r = '0;
    pair_valid = (plan < MAX_PLANS) && (date >= DATE_FLOOR);
    pos = CAPACITY;
    for (int i = set_count - 1; i >= 0; i--) begin
      if (set_plan[i] == plan && set_date[i] == date) begin
        pos = i;
      end
    end
    case (op)
      OP_QUERY: begin
        r.found = pair_valid && (pos < CAPACITY);
      end
      OP_INSERT: begin
        if (!pair_valid) begin
          r.status = 1'b1;
        end else if (pos < CAPACITY) begin
          r.found = 1'b1;
        end else begin
          // A full set gives up its oldest pair to make room.
          if (set_count >= CAPACITY) begin
            drop_entry(0);
            r.evicted = 1'b1;
          end
          set_plan[set_count] = plan;
          set_date[set_count] = date;
          set_count++;
        end
      end
      OP_REMOVE: begin
        if (pos < CAPACITY) begin
          r.found = 1'b1;
          drop_entry(pos);
        end
      end
      default: begin
        set_count = 0;
      end
    endcase
    r.count = set_count[COUNT_W-1:0];
    return r;
  endfunction

  // Offers one operation, waits for the transaction, records its result, then may idle.
  task automatic issue_operation(input func_t op, input logic [PLAN_W-1:0] plan,
                                 input logic [DATE_W-1:0] date);
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, date, plan, op};
    do @(posedge clk); while (!s_tready);
    outcome_q.push_back(apply_operation(op, plan, date));
    if (idle_on && $urandom_range(99) < 28) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  // Receiver: random ready, long hold on request, and result checking.
  always @(posedge clk) begin : result_check
    set_outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
        error_count++;
      end else begin
        want = outcome_q.pop_front();
        if (m_tdata[0] !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_tdata[0]);
          error_count++;
        end
        if (m_tdata[1] !== want.found) begin
          $display("%0t: found expected %0d actual %0d", $time, want.found, m_tdata[1]);
          error_count++;
        end
        if (m_tdata[2] !== want.evicted) begin
          $display("%0t: evicted expected %0d actual %0d", $time, want.evicted, m_tdata[2]);
          error_count++;
        end
        if (m_tdata[7:3] !== want.count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                   m_tdata[7:3]);
          error_count++;
        end
      end
    end
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_token != stall_seen) begin
      m_tready   <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      stall_seen <= stall_token;
    end else begin
      m_tready <= !(idle_on && $urandom_range(99) < 28);
    end
  end

  // Every operation on an empty and a small set, with the invalid pair cases.
  task automatic test_basic_ops();
    issue_operation(OP_QUERY,  8'd0,   DATE_FLOOR);
    issue_operation(OP_REMOVE, 8'd0,   DATE_FLOOR);
    issue_operation(OP_INSERT, 8'd0,   DATE_FLOOR);
    issue_operation(OP_INSERT, 8'd7,   DATE_TOP);
    issue_operation(OP_INSERT, 8'd0,   DATE_FLOOR);
    issue_operation(OP_INSERT, 8'd8,   DATE_FLOOR);
    issue_operation(OP_INSERT, 8'd255, DATE_TOP);
    issue_operation(OP_INSERT, 8'd3,   DATE_FLOOR - DATE_W'(1));
    issue_operation(OP_INSERT, 8'd3,   27'd0);
    issue_operation(OP_QUERY,  8'd0,   DATE_FLOOR);
    // A plan number above the limit whose low bits match a stored plan.
    issue_operation(OP_QUERY,  8'd8,   DATE_FLOOR);
    issue_operation(OP_REMOVE, 8'd8,   DATE_FLOOR);
    issue_operation(OP_REMOVE, 8'd128, DATE_FLOOR);
    issue_operation(OP_QUERY,  8'd7,   DATE_TOP);
    issue_operation(OP_QUERY,  8'd7,   DATE_TOP - DATE_W'(1));
    issue_operation(OP_QUERY,  8'd0,   DATE_FLOOR - DATE_W'(1));
    issue_operation(OP_REMOVE, 8'd0,   DATE_FLOOR);
    issue_operation(OP_QUERY,  8'd0,   DATE_FLOOR);
    issue_operation(OP_INSERT, 8'd5,   27'd20240229);
    issue_operation(OP_REMOVE, 8'd5,   27'd20240229);
    issue_operation(OP_CLEAR,  8'd7,   DATE_TOP);
    issue_operation(OP_QUERY,  8'd7,   DATE_TOP);
    issue_operation(OP_CLEAR,  8'd0,   27'd0);
  endtask

  // Fills the set to capacity, then drives evictions, a middle and a last removal.
  task automatic test_fill_and_evict();
    for (int i = 0; i < CAPACITY; i++) begin
      issue_operation(OP_INSERT, PLAN_W'(i % MAX_PLANS), DATE_FLOOR + DATE_W'(i));
    end
    issue_operation(OP_INSERT, 8'd0, DATE_FLOOR);
    issue_operation(OP_INSERT, 8'd6, DATE_TOP);
    issue_operation(OP_QUERY,  8'd0, DATE_FLOOR);
    issue_operation(OP_QUERY,  8'd1, DATE_FLOOR + DATE_W'(1));
    issue_operation(OP_REMOVE, 8'd0, DATE_FLOOR + DATE_W'(8));
    issue_operation(OP_INSERT, 8'd7, DATE_TOP);
    issue_operation(OP_INSERT, 8'd5, DATE_TOP);
    issue_operation(OP_REMOVE, 8'd5, DATE_TOP);
    issue_operation(OP_REMOVE, 8'd1, DATE_FLOOR + DATE_W'(1));
    issue_operation(OP_CLEAR,  8'd0, 27'd0);
  endtask

  // Receiver holds off for a long stretch while operations keep being offered.
  task automatic test_backpressure();
    stall_token <= stall_token + 1;
    for (int i = 0; i < 30; i++) begin
      issue_operation((i % 3 == 2) ? OP_QUERY : OP_INSERT,
                      PLAN_W'($urandom_range(MAX_PLANS - 1)),
                      DATE_FLOOR + DATE_W'($urandom_range(15)));
    end
  endtask

  // Random operations, mostly on pairs that are stored or likely to collide.
  task automatic test_random(input int n);
    func_t               op;
    logic [PLAN_W-1:0]   plan;
    logic [DATE_W-1:0]   date;
    int                  roll;
    int                  pick;
    for (int k = 0; k < n; k++) begin
      // One long stretch without idling on either side.
      if (k == n / 3) idle_on <= 1'b0;
      if (k == n / 3 + 150) idle_on <= 1'b1;
      roll = $urandom_range(99);
      if (roll < 40) op = OP_INSERT;
      else if (roll < 65) op = OP_QUERY;
      else if (roll < 96) op = OP_REMOVE;
      else op = OP_CLEAR;
      roll = $urandom_range(99);
      if (roll < 45 && set_count > 0) begin
        pick = $urandom_range(set_count - 1);
        plan = set_plan[pick];
        date = set_date[pick];
      end else if (roll < 80) begin
        plan = PLAN_W'($urandom_range(MAX_PLANS - 1));
        date = DATE_FLOOR + DATE_W'($urandom_range(40));
      end else if (roll < 90) begin
        plan = PLAN_W'($urandom_range(MAX_PLANS - 1));
        date = DATE_W'($urandom_range(32'(DATE_TOP), 32'(DATE_FLOOR)));
      end else begin
        plan = PLAN_W'($urandom_range(255));
        date = DATE_W'($urandom_range(32'(DATE_TOP)));
      end
      issue_operation(op, plan, date);
    end
  endtask

  // Main sequence.
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_ops();
    test_fill_and_evict();
    test_backpressure();
    test_random(1000);
    s_tvalid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
hdl/kpset_pkg.sv
hdl/kpset_ram.sv
hdl/keyed_pair_set_fifo_evict_core.sv
verif/tb.sv
